// ===== sv/rtm_pkg.sv =====
// Shared types and constants for the Reinhard tone-mapping pixel pipeline.
`timescale 1ns / 1ps

package rtm_pkg;

  localparam int unsigned NUM_CH = 3;

  // Quotient bits of the final divide, one per pipeline step.
  localparam int unsigned DIV_STEPS = 8;

  typedef logic [15:0] lin_t;     // Q0.16 channel, Q8.8 radiance or gain
  typedef logic [31:0] scaled_t;  // Q16.16 scene value
  typedef logic [32:0] den_t;     // 1 + luminance, Q16.16 with carry bit
  typedef logic [39:0] num_t;     // 255 * scaled value
  typedef logic [7:0]  byte_t;

  typedef lin_t  [NUM_CH-1:0] lin_pix_t;
  typedef scaled_t [NUM_CH-1:0] scaled_pix_t;
  typedef byte_t [NUM_CH-1:0] byte_pix_t;

  // Rec.709 luminance weights in Q0.16, red at index zero. They sum to one.
  localparam logic [NUM_CH-1:0][15:0] LUMA_W = {16'd4732, 16'd46871, 16'd13933};

  localparam den_t  FIX_ONE   = 33'h0_0001_0000;
  localparam byte_t BYTE_FULL = 8'hFF;
  localparam logic [15:0] GAIN_RESET = 16'h0100;

endpackage

// ===== sv/rtm_scale.sv =====
// Exposure stages: radiance times gain, then each channel times that product.
`timescale 1ns / 1ps

module rtm_scale import rtm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  lin_pix_t    chan_i,
  input  lin_t        rad_i,
  input  lin_t        gain_i,
  output logic        vld_o,
  output scaled_pix_t scaled_o
);

  logic        vld1_q, vld2_q;
  lin_pix_t    chan1_q;
  logic [31:0] rg_q;
  scaled_pix_t s_q, s_d;

  // The 48-bit product shifted down by 16 always fits in Q16.16, so the
  // saturation of the scaled value can never trigger.
  always_comb begin
    logic [47:0] prod;
    for (int c = 0; c < NUM_CH; c++) begin
      prod   = 48'(chan1_q[c]) * 48'(rg_q);
      s_d[c] = prod[47:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan1_q <= chan_i;
      rg_q    <= 32'(rad_i) * 32'(gain_i);
      s_q     <= s_d;
    end
  end

  assign vld_o    = vld2_q;
  assign scaled_o = s_q;

endmodule

// ===== sv/rtm_luma.sv =====
// Luminance stages: weighted channel products, then the 1 + L denominator.
`timescale 1ns / 1ps

module rtm_luma import rtm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  scaled_pix_t scaled_i,
  output logic        vld_o,
  output scaled_pix_t scaled_o,
  output den_t        den_o
);

  logic                    vld3_q, vld4_q;
  logic [NUM_CH-1:0][47:0] wp_q;
  scaled_pix_t             s3_q, s4_q;
  den_t                    den_q, den_d;

  // The weights sum to exactly one, so the weighted sum stays below 2^48.
  always_comb begin
    logic [47:0] sum;
    sum   = wp_q[0] + wp_q[1] + wp_q[2];
    den_d = FIX_ONE + {1'b0, sum[47:16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld3_q <= vld_i;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < NUM_CH; c++) begin
        wp_q[c] <= 48'(LUMA_W[c]) * 48'(scaled_i[c]);
      end
      s3_q  <= scaled_i;
      s4_q  <= s3_q;
      den_q <= den_d;
    end
  end

  assign vld_o    = vld4_q;
  assign scaled_o = s4_q;
  assign den_o    = den_q;

endmodule

// ===== sv/rtm_div.sv =====
// Clamp and restoring divide, one quotient bit per stage, for all three channels.
`timescale 1ns / 1ps

module rtm_div import rtm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  scaled_pix_t scaled_i,
  input  den_t        den_i,
  output logic        vld_o,
  output byte_pix_t   byte_o
);

  logic [DIV_STEPS:0]                    vld_q;
  den_t [DIV_STEPS:0]                    den_q;
  logic [DIV_STEPS:0][NUM_CH-1:0]        sat_q;
  logic [DIV_STEPS:0][NUM_CH-1:0][39:0]  rem_q;
  logic [DIV_STEPS:0][NUM_CH-1:0][7:0]   quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STEPS-1:0], vld_i};
    end
  end

  // Entry stage: a channel at or above the denominator clamps to full scale;
  // otherwise the numerator 255 * s is below 255 * D and the quotient fits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
      for (int c = 0; c < NUM_CH; c++) begin
        sat_q[0][c] <= {1'b0, scaled_i[c]} >= den_i;
        rem_q[0][c] <= {scaled_i[c], 8'h00} - {8'h00, scaled_i[c]};
        quo_q[0][c] <= '0;
      end
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int unsigned Bit = DIV_STEPS - 1 - j;
    num_t                          dsh;
    logic [NUM_CH-1:0][39:0]       rem_d;
    logic [NUM_CH-1:0][7:0]        quo_d;

    always_comb begin
      dsh = num_t'({7'h00, den_q[j]} << Bit);
      for (int c = 0; c < NUM_CH; c++) begin
        rem_d[c] = rem_q[j][c];
        quo_d[c] = quo_q[j][c];
        if (rem_q[j][c] >= dsh) begin
          rem_d[c]      = rem_q[j][c] - dsh;
          quo_d[c][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j+1] <= den_q[j];
        sat_q[j+1] <= sat_q[j];
        rem_q[j+1] <= rem_d;
        quo_q[j+1] <= quo_d;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      byte_o[c] = sat_q[DIV_STEPS][c] ? BYTE_FULL : quo_q[DIV_STEPS][c];
    end
  end

  assign vld_o = vld_q[DIV_STEPS];

  // After the last step the remainder of an unclamped channel is below D; red is checked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_STEPS] && !sat_q[DIV_STEPS][0] |->
      {1'b0, rem_q[DIV_STEPS][0]} < {8'h00, den_q[DIV_STEPS]})
    else $error("rtm_div: red remainder not below denominator");

  // An unclamped channel is strictly below one, so its quotient is at most 254; green is checked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_STEPS] && !sat_q[DIV_STEPS][1] |-> quo_q[DIV_STEPS][1] != BYTE_FULL)
    else $error("rtm_div: green quotient reached full scale without clamp");

endmodule

// ===== sv/rtm_skid.sv =====
// Output register with a one-entry skid stage that decouples the two ready paths.
`timescale 1ns / 1ps

module rtm_skid import rtm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  input  byte_pix_t data_i,
  output logic      rdy_o,
  output logic      vld_o,
  output byte_pix_t data_o,
  input  logic      rdy_i
);

  logic      out_vld_q, skid_vld_q;
  byte_pix_t out_q, skid_q;
  logic      take_out, accept;

  assign rdy_o    = !skid_vld_q;
  assign accept   = vld_i && rdy_o;
  assign take_out = rdy_i || !out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (take_out) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= vld_i;
      end
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_out) begin
      out_q <= skid_vld_q ? skid_q : data_i;
    end else if (accept) begin
      skid_q <= data_i;
    end
  end

  assign vld_o  = out_vld_q;
  assign data_o = out_q;

  // The skid entry is only ever filled behind a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("rtm_skid: skid entry held with empty output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !rdy_i && vld_i))
    else $error("rtm_skid: skid filled without a stalled request");

  // A held skid entry moves to the output as soon as the output is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && rdy_i |=> out_vld_q && data_o == $past(skid_q))
    else $error("rtm_skid: skid entry not forwarded");

endmodule

// ===== sv/reinhard_tone_map_pixel.sv =====
// Top level of the Reinhard global tone-mapping pixel pipeline.
//
//   Channel   Direction  Signals                         Payload
//   s_axis    in         tvalid / tready / tdata[63:0]   linear pixel and radiance
//   m_axis    out        tvalid / tready / tdata[23:0]   tone-mapped sRGB bytes
//   cfg       in         valid / ready / data[15:0]      exposure gain, Q8.8
//
// One pixel request is accepted per cycle while s_axis_tready is high. A pixel
// passes thirteen register stages (two exposure multiplies, two luminance stages,
// the clamp stage and eight divide steps) and then the output register.
// Reset clears every valid bit and sets the exposure gain to 1.0.
// A stall on m_axis fills the skid entry when a result arrives; s_axis_tready is low
// while that entry is full, and the whole pipeline holds until the output is taken.
`timescale 1ns / 1ps

module reinhard_tone_map_pixel import rtm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // red_linear, green_linear, blue_linear, radiance
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_byte, green_byte, blue_byte
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  lin_t        gain_q;
  logic        en;
  lin_pix_t    chan;
  logic        sc_vld, lu_vld, dv_vld;
  scaled_pix_t sc_val, lu_val;
  den_t        lu_den;
  byte_pix_t   dv_byte, out_byte;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  assign chan[0] = s_axis_tdata[15:0];
  assign chan[1] = s_axis_tdata[31:16];
  assign chan[2] = s_axis_tdata[47:32];

  // The whole pipeline moves together whenever the skid entry is free.
  assign s_axis_tready = en;

  rtm_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (s_axis_tvalid),
    .chan_i   (chan),
    .rad_i    (s_axis_tdata[63:48]),
    .gain_i   (gain_q),
    .vld_o    (sc_vld),
    .scaled_o (sc_val)
  );

  rtm_luma u_luma (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (sc_vld),
    .scaled_i (sc_val),
    .vld_o    (lu_vld),
    .scaled_o (lu_val),
    .den_o    (lu_den)
  );

  rtm_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (lu_vld),
    .scaled_i (lu_val),
    .den_i    (lu_den),
    .vld_o    (dv_vld),
    .byte_o   (dv_byte)
  );

  rtm_skid u_skid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (dv_vld),
    .data_i (dv_byte),
    .rdy_o  (en),
    .vld_o  (m_axis_tvalid),
    .data_o (out_byte),
    .rdy_i  (m_axis_tready)
  );

  assign m_axis_tdata = out_byte;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Reinhard tone-mapping pixel pipeline.
`timescale 1ns / 1ps

module tb import rtm_pkg::*;;

  // Rec.709 luminance weights in Q0.16 and the fixed-point one of Q16.16.
  localparam logic [63:0] WEIGHT_RED   = 64'd13933;
  localparam logic [63:0] WEIGHT_GREEN = 64'd46871;
  localparam logic [63:0] WEIGHT_BLUE  = 64'd4732;
  localparam logic [63:0] Q16_ONE      = 64'd65536;
  localparam logic [15:0] GAIN_UNITY   = 16'h0100;
  localparam logic [15:0] GAIN_MAX     = 16'hFFFF;
  localparam logic [15:0] GAIN_ZERO    = 16'h0000;
  localparam logic [15:0] GAIN_MIN     = 16'h0001;
  // Margin after the pipeline drains, before the gain is touched.
  localparam int          DRAIN_CYCLES = 24;
  localparam int          SEGMENT_LEN  = 110;
  localparam int          SEGMENTS     = 5;
  localparam int          NUM_DIRECTED = 18;

  // Packs exactly like s_axis_tdata: red in the lowest bits, radiance on top.
  typedef struct packed {
    lin_t     radiance;
    lin_pix_t chan;
  } pixel_t;

  typedef struct packed {
    lin_t        red;
    lin_t        green;
    lin_t        blue;
    lin_t        radiance;
    logic [15:0] gain;
    logic        known;
    byte_t       want_red;
    byte_t       want_green;
    byte_t       want_blue;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // red_linear, green_linear, blue_linear, radiance
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // red_byte, green_byte, blue_byte
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  byte_pix_t   pending_tones[$];
  logic [15:0] exposure_gain;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  byte_pix_t   got_tone;
  byte_pix_t   want_tone;
  string       chan_names[3] = '{"red", "green", "blue"};

  // Rows whose expected bytes are typed in are the ones that follow directly from
  // zero scaling or a channel far above its own luminance share; the rest use tone_map.
  directed_row_t directed_rows[NUM_DIRECTED] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, GAIN_UNITY, 1'b1, 8'h00, 8'h00, 8'h00},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, GAIN_UNITY, 1'b1, 8'h00, 8'h00, 8'h00},
    '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, GAIN_UNITY, 1'b1, 8'hFF, 8'h00, 8'h00},
    '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, GAIN_UNITY, 1'b1, 8'h00, 8'hFF, 8'h00},
    '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, GAIN_UNITY, 1'b1, 8'h00, 8'h00, 8'hFF},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0100, GAIN_UNITY, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, GAIN_UNITY, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, GAIN_UNITY, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, GAIN_UNITY, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h0001, 16'h0001, 16'h0001, 16'h0001, GAIN_UNITY, 1'b1, 8'h00, 8'h00, 8'h00},
    '{16'h8000, 16'h4000, 16'h0001, 16'h0100, GAIN_UNITY, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, GAIN_ZERO,  1'b1, 8'h00, 8'h00, 8'h00},
    '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, GAIN_ZERO,  1'b1, 8'h00, 8'h00, 8'h00},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, GAIN_MAX,   1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h0001, 16'h0100, 16'h8000, 16'h0001, GAIN_MAX,   1'b0, 8'h00, 8'h00, 8'h00},
    '{16'hFFFF, 16'h0000, 16'h0000, 16'h0100, GAIN_MAX,   1'b0, 8'h00, 8'h00, 8'h00},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, GAIN_MIN,   1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h1234, 16'hFEDC, 16'h00FF, 16'h0F0F, GAIN_MIN,   1'b0, 8'h00, 8'h00, 8'h00}
  };

  reinhard_tone_map_pixel i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Q16.16 scene value of one channel; the 48-bit product is kept before the shift.
  function automatic logic [63:0] scene_value(lin_t chan, lin_t radiance, logic [15:0] gain);
    logic [63:0] prod;
    prod = (64'(chan) * 64'(radiance) * 64'(gain)) >> 16;
    if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
    return prod;
  endfunction

  function automatic byte_pix_t tone_map(pixel_t px, logic [15:0] gain);
    logic [63:0] scene[3];
    logic [63:0] luma;
    logic [63:0] den;
    byte_pix_t   tone;
    for (int c = 0; c < 3; c++) scene[c] = scene_value(px.chan[c], px.radiance, gain);
    luma = (WEIGHT_RED * scene[0] + WEIGHT_GREEN * scene[1] + WEIGHT_BLUE * scene[2]) >> 16;
    den = Q16_ONE + luma;
    for (int c = 0; c < 3; c++) begin
      if (scene[c] >= den) tone[c] = 8'hFF;
      else tone[c] = byte_t'((scene[c] * 64'd255) / den);
    end
    return tone;
  endfunction

  // Arbitrary values half the time, with zeros, full scale and small values mixed in.
  function automatic lin_t random_level();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return lin_t'($urandom_range(0, 1023));
      default: return lin_t'($urandom);
    endcase
  endfunction

  task automatic send_pixel(pixel_t px, byte_pix_t want);
    int gap;
    // Each cycle is idle with the same chance, so the idle share matches the percentage.
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_tones.push_back(want);
  endtask

  // Stops sending until every outstanding pixel has come back, then lets the pipe settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_tones.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [15:0] gain);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= gain;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i   <= 1'b0;
    exposure_gain = gain;
  endtask

  // Output side: random back-pressure and in-order comparison of every result.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_tone = m_axis_tdata;
      if (pending_tones.size() == 0) begin
        errors++;
        $display("%0t: unexpected result 0x%06h, expected none", $time, got_tone);
      end else begin
        want_tone = pending_tones.pop_front();
        for (int c = 0; c < 3; c++) begin
          if (got_tone[c] !== want_tone[c]) begin
            errors++;
            $display("%0t: %s byte expected %0d, actual %0d", $time, chan_names[c],
                     want_tone[c], got_tone[c]);
          end
        end
      end
    end
  end

  initial begin
    pixel_t      px;
    byte_pix_t   want;
    logic [15:0] gain;
    exposure_gain = GAIN_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 24;
    recv_idle_pct = 52;
    // The first rows run on the gain left by reset.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_rows[i].gain != exposure_gain) write_gain(directed_rows[i].gain);
      px.chan     = {directed_rows[i].blue, directed_rows[i].green, directed_rows[i].red};
      px.radiance = directed_rows[i].radiance;
      if (directed_rows[i].known)
        want = {directed_rows[i].want_blue, directed_rows[i].want_green,
                directed_rows[i].want_red};
      else
        want = tone_map(px, exposure_gain);
      send_pixel(px, want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 24 : 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        case (seg)
          0:       gain = 16'($urandom_range(128, 512));
          1:       gain = 16'($urandom);
          2:       gain = (phase == 1) ? GAIN_MAX : 16'($urandom_range(512, 4096));
          3:       gain = 16'($urandom_range(1, 64));
          default: gain = (phase == 0) ? GAIN_ZERO : GAIN_UNITY;
        endcase
        write_gain(gain);
        for (int n = 0; n < SEGMENT_LEN; n++) begin
          for (int c = 0; c < 3; c++) px.chan[c] = random_level();
          px.radiance = ($urandom_range(0, 1) == 0) ? lin_t'($urandom_range(0, 1024))
                                                    : random_level();
          send_pixel(px, tone_map(px, exposure_gain));
        end
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
